[hdl/swhs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swhs_pkg
// Shared types and constants for the single-wire humidity sensor reader.
// ----------------------------------------------------------------------------
package swhs_pkg;

   localparam int FRAME_BYTES     = 5;   // four data bytes and the checksum
   localparam int CHECKSUM_BYTE   = 4;
   localparam int FIRST_DATA_EDGE = 4;   // first transition that closes a bit
   localparam int QUEUE_DEPTH     = 4;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_DATA_W      = 16;
   localparam int RSP_DATA_W      = 40;

   localparam logic [15:0] RST_START_LOW = 16'd18000;
   localparam logic [9:0]  RST_RELEASE   = 10'd40;
   localparam logic [7:0]  RST_ONE_THR   = 8'd16;
   localparam logic [7:0]  RST_TIMEOUT   = 8'd255;

   // configuration register indexes
   localparam logic [1:0] CSR_START_LOW = 2'd0;
   localparam logic [1:0] CSR_RELEASE   = 2'd1;
   localparam logic [1:0] CSR_ONE_THR   = 2'd2;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd3;

   typedef enum logic [1:0] {
      PH_IDLE,
      PH_LOW,
      PH_RELEASE,
      PH_LISTEN
   } phase_type;

   typedef logic [FRAME_BYTES-1:0][7:0] frame_type;   // [0] is the first byte

   typedef struct packed {
      logic [15:0] start_low;
      logic [9:0]  release_ticks;
      logic [7:0]  one_thr;
      logic [7:0]  timeout;
   } cfg_type;

   // one classified tick on its way from front to back
   typedef struct packed {
      logic      drive;
      logic      done;
      logic      full;    // every frame bit arrived
      frame_type frame;
   } rec_type;

endpackage : swhs_pkg
`default_nettype wire

[hdl/swhs_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swhs_front
// Protocol sequencer: runs the start pulse, release window and edge timing,
// and shifts decoded bits into the frame. One record per accepted beat.
// ----------------------------------------------------------------------------
module swhs_front #(
   parameter int MAX_TRANSITIONS = 85,
   parameter int FRAME_BITS      = 40
) (
   input  wire                 clock,
   input  wire                 reset,
   input  swhs_pkg::cfg_type   cfg,
   input  wire                 in_valid,
   output logic                in_ready,
   input  wire                 in_action,
   input  wire                 in_level,
   output logic                push_valid,
   input  wire                 push_ready,
   output swhs_pkg::rec_type   push_rec
);
   import swhs_pkg::*;

   localparam int TW = $clog2(MAX_TRANSITIONS + 1);
   localparam int BW = $clog2(FRAME_BITS + 1);

   phase_type   phase_ff, phase_in;
   logic [15:0] timer_ff, timer_in, timer_inc;
   logic        prev_ff, prev_in;
   logic [7:0]  dur_ff, dur_in;
   logic [TW-1:0] tidx_ff, tidx_in, tidx_inc;
   logic [BW-1:0] bits_ff, bits_in;
   frame_type   frame_ff, frame_in;
   logic        drive, done, take, bit_val, fire;

   assign in_ready   = push_ready;
   assign push_valid = in_valid;
   assign fire       = in_valid && push_ready;

   always_comb begin
      phase_in  = phase_ff;
      timer_in  = timer_ff;
      prev_in   = prev_ff;
      dur_in    = dur_ff;
      tidx_in   = tidx_ff;
      bits_in   = bits_ff;
      frame_in  = frame_ff;
      drive     = 1'b0;
      done      = 1'b0;
      take      = 1'b0;
      bit_val   = (dur_ff > cfg.one_thr);
      timer_inc = timer_ff + 16'd1;
      tidx_inc  = tidx_ff + TW'(1);
      if (in_action) begin
         // restart: clear everything and pull the line low at once
         frame_in = '0;
         bits_in  = '0;
         tidx_in  = '0;
         dur_in   = '0;
         prev_in  = 1'b1;
         timer_in = '0;
         phase_in = PH_LOW;
         drive    = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_LOW: begin
               drive    = 1'b1;
               timer_in = timer_inc;
               if (timer_inc >= cfg.start_low) begin
                  timer_in = '0;
                  phase_in = (cfg.release_ticks == '0) ? PH_LISTEN : PH_RELEASE;
               end
            end
            PH_RELEASE: begin
               timer_in = timer_inc;
               if (timer_inc >= {6'd0, cfg.release_ticks}) begin
                  timer_in = '0;
                  phase_in = PH_LISTEN;
               end
            end
            PH_LISTEN: begin
               if (in_level == prev_ff) begin
                  dur_in = dur_ff + 8'd1;
               end else begin
                  take    = (tidx_ff >= TW'(FIRST_DATA_EDGE)) && !tidx_ff[0]
                            && (bits_ff < BW'(FRAME_BITS));
                  tidx_in = tidx_inc;
                  prev_in = in_level;
                  dur_in  = 8'd1;
                  done    = (tidx_inc >= TW'(MAX_TRANSITIONS));
               end
               if (dur_in >= cfg.timeout) begin
                  done = 1'b1;
               end
               if (take) begin
                  bits_in = bits_ff + BW'(1);
                  for (int b = 0; b < FRAME_BYTES; b++) begin
                     if ((bits_ff >> 3) == BW'(b)) begin
                        frame_in[b] = {frame_ff[b][6:0], bit_val};
                     end
                  end
               end
               if (done) begin
                  phase_in = PH_IDLE;
               end
            end
            default: begin
               // idle tick: release the line, hold state
            end
         endcase
      end
      push_rec.drive = drive;
      push_rec.done  = done;
      push_rec.full  = (bits_in >= BW'(FRAME_BITS));
      push_rec.frame = frame_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         timer_ff <= '0;
         prev_ff  <= 1'b1;
         dur_ff   <= '0;
         tidx_ff  <= '0;
         bits_ff  <= '0;
         frame_ff <= '0;
      end else if (fire) begin
         phase_ff <= phase_in;
         timer_ff <= timer_in;
         prev_ff  <= prev_in;
         dur_ff   <= dur_in;
         tidx_ff  <= tidx_in;
         bits_ff  <= bits_in;
         frame_ff <= frame_in;
      end
   end

`ifndef SYNTHESIS
   a_start_enters_low : assert property (@(posedge clock) disable iff (reset)
      (fire && in_action) |=> (phase_ff == PH_LOW && bits_ff == '0 && tidx_ff == '0))
      else $error("start beat did not restart the sequencer");

   a_bits_bounded : assert property (@(posedge clock) disable iff (reset)
      bits_ff <= BW'(FRAME_BITS))
      else $error("bit count ran past the frame length");

   a_done_goes_idle : assert property (@(posedge clock) disable iff (reset)
      (fire && push_rec.done) |=> (phase_ff == PH_IDLE))
      else $error("finished read left the sequencer busy");
`endif

endmodule : swhs_front
`default_nettype wire

[hdl/swhs_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swhs_queue
// Short FIFO of classified records between the sequencer and the output.
// ----------------------------------------------------------------------------
module swhs_queue (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 push_valid,
   output logic                push_ready,
   input  swhs_pkg::rec_type   push_rec,
   output logic                pop_valid,
   input  wire                 pop_ready,
   output swhs_pkg::rec_type   pop_rec
);
   import swhs_pkg::*;

   rec_type                 q_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ff, rd_ff;
   logic [QUEUE_CNT_W-1:0]  count_ff;
   logic                    push_fire, pop_fire;

   assign push_ready = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_rec    = q_ff[rd_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (push_fire) begin
         q_ff[wr_ff] <= push_rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         if (push_fire) begin
            wr_ff <= wr_ff + QUEUE_PTR_W'(1);
         end
         if (pop_fire) begin
            rd_ff <= rd_ff + QUEUE_PTR_W'(1);
         end
         if (push_fire && !pop_fire) begin
            count_ff <= count_ff + QUEUE_CNT_W'(1);
         end else if (pop_fire && !push_fire) begin
            count_ff <= count_ff - QUEUE_CNT_W'(1);
         end
      end
   end

`ifndef SYNTHESIS
   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue overfilled");

   a_count_tracks : assert property (@(posedge clock) disable iff (reset)
      (push_fire && !pop_fire) |=> (count_ff == $past(count_ff) + QUEUE_CNT_W'(1)))
      else $error("queue lost a pushed record");
`endif

endmodule : swhs_queue
`default_nettype wire

[hdl/swhs_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swhs_back
// Result stage: checks the frame sum on finished reads and holds the
// outgoing beat in an output register.
// ----------------------------------------------------------------------------
module swhs_back (
   input  wire                            clock,
   input  wire                            reset,
   input  wire                            pop_valid,
   output logic                           pop_ready,
   input  swhs_pkg::rec_type              pop_rec,
   output logic                           rsp_tvalid,
   input  wire                            rsp_tready,
   output logic [swhs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   output logic                           rsp_tuser
);
   import swhs_pkg::*;

   logic                  valid_ff;
   logic [RSP_DATA_W-1:0] data_ff, data_in;
   logic                  last_ff, user_ff, user_in;
   logic [7:0]            sum;
   logic                  load;

   assign pop_ready = !valid_ff || rsp_tready;
   assign load      = pop_valid && pop_ready;

   always_comb begin
      sum     = pop_rec.frame[0] + pop_rec.frame[1] + pop_rec.frame[2]
                + pop_rec.frame[3];
      user_in = pop_rec.done && pop_rec.full
                && (sum == pop_rec.frame[CHECKSUM_BYTE]);
      data_in = '0;
      data_in[0] = pop_rec.drive;
      if (pop_rec.done) begin
         data_in[32:1] = {pop_rec.frame[3], pop_rec.frame[2],
                          pop_rec.frame[1], pop_rec.frame[0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (pop_ready) begin
         valid_ff <= pop_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
         last_ff <= pop_rec.done;
         user_ff <= user_in;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tuser  = user_ff;

endmodule : swhs_back
`default_nettype wire

[hdl/single_wire_humidity_sensor_reader_top.sv]
`timescale 1ns / 1ps
`default_nettype none
// Each record is registered in the record queue, then in the output register.
// Throughput: 1 beat per cycle while the record queue is not full; the sequencer updates once per tick.
// A 4-entry record queue lets the sequencer run on while the result stalls.
// Reset (synchronous, active high) idles the sequencer, empties the queue,
// drops rsp_tvalid and loads the register defaults 18000 / 40 / 16 / 255.
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_top
// Reader for a single-wire temperature and humidity sensor: start pulse,
// release window, pulse-width bit decode of a 40-bit frame, checksum check.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader_top #(
   parameter int MAX_TRANSITIONS = 85,   // edges that end a read, 8..127
   parameter int FRAME_BITS      = 40    // bits in a full frame, 8..40
) (
   input  wire        clock,
   input  wire        reset,
   // request beats: one tick or a start command
   input  wire        req_tvalid,
   output logic       req_tready,
   input  wire  [7:0] req_tdata,    // [0] line_level, [7:1] zero
   input  wire        req_tuser,    // [0] action (0 tick, 1 start)
   // result beats: one per request
   output logic       rsp_tvalid,
   input  wire        rsp_tready,
   output logic [swhs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] drive_low, [8:1] humidity_whole, [16:9] humidity_tenths,
   // [24:17] temperature_whole, [32:25] temperature_tenths, [39:33] zero
   output logic       rsp_tlast,    // done_res
   output logic       rsp_tuser,    // [0] data_ok
   // register writes
   input  wire        csr_valid,
   output logic       csr_ready,
   input  wire  [1:0] csr_index,
   input  wire  [swhs_pkg::CSR_DATA_W-1:0] csr_data
);
   import swhs_pkg::*;

   cfg_type cfg_ff;
   logic    push_valid, push_ready, pop_valid, pop_ready;
   rec_type push_rec, pop_rec;

   // Register file: always ready, writes land on the accepting edge.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_low     <= RST_START_LOW;
         cfg_ff.release_ticks <= RST_RELEASE;
         cfg_ff.one_thr       <= RST_ONE_THR;
         cfg_ff.timeout       <= RST_TIMEOUT;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_START_LOW: cfg_ff.start_low     <= csr_data;
            CSR_RELEASE:   cfg_ff.release_ticks <= csr_data[9:0];
            CSR_ONE_THR:   cfg_ff.one_thr       <= csr_data[7:0];
            CSR_TIMEOUT:   cfg_ff.timeout       <= csr_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // Front: advance the protocol one tick per beat and classify it.
   swhs_front #(
      .MAX_TRANSITIONS (MAX_TRANSITIONS),
      .FRAME_BITS      (FRAME_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_action  (req_tuser),
      .in_level   (req_tdata[0]),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec)
   );

   // Queue: decouple the sequencer from result backpressure.
   swhs_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_rec   (push_rec),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec)
   );

   // Back: check the sum and register the outgoing beat.
   swhs_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_rec    (pop_rec),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule : single_wire_humidity_sensor_reader_top
`default_nettype wire

[sim/swhs_reader_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swhs_reader_checker
// Watches the request, result and register channels of the sensor reader,
// runs its own copy of the reader state per request beat and compares every
// result beat, field by field, with the oldest predicted reply.
// ----------------------------------------------------------------------------
module swhs_reader_checker #(
   parameter int MAX_TRANSITIONS = 85,
   parameter int FRAME_BITS      = 40
) (
   input  wire        clock,
   input  wire        reset,
   input  wire        req_tvalid,
   input  wire        req_tready,
   input  wire  [7:0] req_tdata,    // [0] line_level, [7:1] zero
   input  wire        req_tuser,    // [0] action (0 tick, 1 start)
   input  wire        rsp_tvalid,
   input  wire        rsp_tready,
   input  wire  [swhs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // [0] drive_low, [8:1] humidity_whole, [16:9] humidity_tenths,
   // [24:17] temperature_whole, [32:25] temperature_tenths, [39:33] zero
   input  wire        rsp_tlast,    // done_res
   input  wire        rsp_tuser,    // [0] data_ok
   input  wire        csr_valid,
   input  wire        csr_ready,
   input  wire  [1:0] csr_index,
   input  wire  [swhs_pkg::CSR_DATA_W-1:0] csr_data,
   output int         fail_count,
   output int         pending
);
   import swhs_pkg::*;

   typedef struct packed {
      logic            drive;
      logic            done;
      logic            ok;
      logic [3:0][7:0] bytes;          // [0] humidity_whole
   } sensor_reply_type;

   string byte_label [4] = '{"humidity_whole", "humidity_tenths",
                             "temperature_whole", "temperature_tenths"};

   // reader state and registers as the block should hold them
   phase_type     rd_phase;
   logic [15:0]   phase_ticks;
   logic          last_level;
   logic [7:0]    level_len;
   logic [6:0]    edge_count;
   logic [5:0]    bit_count;
   frame_type     frame_bytes;
   cfg_type       cfg;

   sensor_reply_type reply_q [$];
   sensor_reply_type got;
   sensor_reply_type want;

   task automatic flag_mismatch(input string what);
      fail_count++;
      $display("%0t ns mismatch: %s", $time, what);
   endtask

   // advance the reader by one request beat and return the reply it gives
   function automatic sensor_reply_type advance_reader(input logic is_start,
                                                       input logic lvl);
      sensor_reply_type r;
      logic             finish;
      logic [7:0]       sum;
      int               k;
      r      = '0;
      finish = 1'b0;
      if (is_start) begin
         frame_bytes = '0;
         bit_count   = '0;
         edge_count  = '0;
         level_len   = '0;
         last_level  = 1'b1;
         phase_ticks = '0;
         rd_phase    = PH_LOW;
         r.drive     = 1'b1;
      end else begin
         case (rd_phase)
            PH_LOW: begin
               r.drive = 1'b1;
               phase_ticks++;
               if (phase_ticks >= cfg.start_low) begin
                  phase_ticks = '0;
                  rd_phase    = (cfg.release_ticks == '0) ? PH_LISTEN : PH_RELEASE;
               end
            end
            PH_RELEASE: begin
               phase_ticks++;
               if (phase_ticks >= 16'(cfg.release_ticks)) begin
                  phase_ticks = '0;
                  rd_phase    = PH_LISTEN;
               end
            end
            PH_LISTEN: begin
               if (lvl == last_level) begin
                  level_len++;
               end else begin
                  // even edges from the first data edge on close a bit's high time
                  if (int'(edge_count) >= FIRST_DATA_EDGE && !edge_count[0] &&
                      int'(bit_count) < FRAME_BITS) begin
                     k = int'(bit_count) / 8;
                     frame_bytes[k] = {frame_bytes[k][6:0], level_len > cfg.one_thr};
                     bit_count++;
                  end
                  edge_count++;
                  last_level = lvl;
                  level_len  = 8'd1;
                  if (int'(edge_count) >= MAX_TRANSITIONS) finish = 1'b1;
               end
               if (!finish && level_len >= cfg.timeout) finish = 1'b1;
               if (finish) rd_phase = PH_IDLE;
            end
            default: ;
         endcase
      end
      if (finish) begin
         sum     = frame_bytes[0] + frame_bytes[1] + frame_bytes[2] + frame_bytes[3];
         r.done  = 1'b1;
         r.ok    = (int'(bit_count) >= FRAME_BITS) && (sum == frame_bytes[CHECKSUM_BYTE]);
         r.bytes = frame_bytes[3:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         rd_phase    = PH_IDLE;
         phase_ticks = '0;
         last_level  = 1'b1;
         level_len   = '0;
         edge_count  = '0;
         bit_count   = '0;
         frame_bytes = '0;
         cfg         = '{RST_START_LOW, RST_RELEASE, RST_ONE_THR, RST_TIMEOUT};
         reply_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_START_LOW: cfg.start_low     = csr_data;
               CSR_RELEASE:   cfg.release_ticks = csr_data[9:0];
               CSR_ONE_THR:   cfg.one_thr       = csr_data[7:0];
               CSR_TIMEOUT:   cfg.timeout       = csr_data[7:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            reply_q.push_back(advance_reader(req_tuser, req_tdata[0]));
         if (rsp_tvalid && rsp_tready) begin
            got.drive    = rsp_tdata[0];
            got.bytes[0] = rsp_tdata[8:1];
            got.bytes[1] = rsp_tdata[16:9];
            got.bytes[2] = rsp_tdata[24:17];
            got.bytes[3] = rsp_tdata[32:25];
            got.done     = rsp_tlast;
            got.ok       = rsp_tuser;
            if (reply_q.size() == 0) begin
               flag_mismatch("result beat with no request behind it");
            end else begin
               want = reply_q.pop_front();
               if (got.drive !== want.drive)
                  flag_mismatch($sformatf("drive_low got %0b expected %0b",
                                          got.drive, want.drive));
               if (got.done !== want.done)
                  flag_mismatch($sformatf("done_res got %0b expected %0b",
                                          got.done, want.done));
               if (got.ok !== want.ok)
                  flag_mismatch($sformatf("data_ok got %0b expected %0b",
                                          got.ok, want.ok));
               for (int i = 0; i < 4; i++) begin
                  if (got.bytes[i] !== want.bytes[i])
                     flag_mismatch($sformatf("%s got %02h expected %02h", byte_label[i],
                                             got.bytes[i], want.bytes[i]));
               end
            end
         end
      end
      pending = reply_q.size();
   end

endmodule : swhs_reader_checker

[sim/single_wire_humidity_sensor_reader_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// single_wire_humidity_sensor_reader_top_test
// Drives start commands and line samples into the sensor reader: a short
// directed run over the corner cases, then sensor frames with random bytes,
// broken frames and line noise under several register settings and idle
// patterns. The checker beside the block predicts and compares each result.
// ----------------------------------------------------------------------------
module single_wire_humidity_sensor_reader_top_test;
   import swhs_pkg::*;

   localparam int MAX_TRANSITIONS = 85;
   localparam int FRAME_BITS      = 40;
   localparam int LONG_HOLD       = 64;     // receiver hold-off, long enough to fill the block
   localparam int DRAIN_PAUSE     = 8;      // margin after the last result comes back
   localparam int WATCHDOG_LIMIT  = 2000;   // cycles without any beat
   localparam int PHASE_ITEMS     = 100;
   localparam int PHASE_READINGS  = 1;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata  = '0;    // [0] line_level, [7:1] zero
   logic                  req_tuser  = 1'b0;  // [0] action (0 tick, 1 start)
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   // [0] drive_low, [8:1] humidity_whole, [16:9] humidity_tenths,
   // [24:17] temperature_whole, [32:25] temperature_tenths, [39:33] zero
   logic                  rsp_tlast;          // done_res
   logic                  rsp_tuser;          // [0] data_ok
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [1:0]            csr_index  = CSR_START_LOW;
   logic [CSR_DATA_W-1:0] csr_data   = '0;

   int fail_count;
   int pending;

   // idle pattern, set by the stimulus and read by the beat processes
   int req_gap_pct   = 0;
   int rsp_stall_pct = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   int items_sent    = 0;
   int readings_sent = 0;

   // register values currently in the block, used to time the sensor frames
   int cur_start_low = RST_START_LOW;
   int cur_release   = RST_RELEASE;
   int cur_thr       = RST_ONE_THR;
   int cur_timeout   = RST_TIMEOUT;

   always #4 clock = ~clock;

   single_wire_humidity_sensor_reader_top #(
      .MAX_TRANSITIONS (MAX_TRANSITIONS),
      .FRAME_BITS      (FRAME_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   swhs_reader_checker #(
      .MAX_TRANSITIONS (MAX_TRANSITIONS),
      .FRAME_BITS      (FRAME_BITS)
   ) u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Result side. A long hold-off, once asked for, is counted out here;
   // otherwise stall at random by the current percentage.
   always @(negedge clock) begin
      if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left  <= hold_left - 1;
      end else if (holds_served != hold_requests) begin
         holds_served <= holds_served + 1;
         hold_left    <= LONG_HOLD;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   // Watchdog: any accepted beat on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("single_wire_humidity_sensor_reader_top verification failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request beat, with a random gap in front, and hold it until
   // accepted. Returns on the falling edge after the accepting edge, valid
   // still high so back-to-back beats never drop it.
   task automatic send_beat(input logic is_start, input logic lvl);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= is_start;
      req_tdata  <= {7'd0, lvl};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      items_sent++;
   endtask

   // hold the sensor line at one level for n ticks
   task automatic hold_level(input logic lvl, input int n);
      repeat (n) send_beat(1'b0, lvl);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_PAUSE) @(negedge clock);
   endtask

   // Write all four registers while the block is idle.
   task automatic set_config(input int start_low, input int release_len,
                             input int one_thr, input int timeout_len);
      logic [1:0]            reg_order [4];
      logic [CSR_DATA_W-1:0] reg_value [4];
      reg_order = '{CSR_START_LOW, CSR_RELEASE, CSR_ONE_THR, CSR_TIMEOUT};
      reg_value = '{CSR_DATA_W'(start_low), CSR_DATA_W'(release_len),
                    CSR_DATA_W'(one_thr), CSR_DATA_W'(timeout_len)};
      wait_drained();
      for (int i = 0; i < 4; i++) begin
         csr_valid <= 1'b1;
         csr_index <= reg_order[i];
         csr_data  <= reg_value[i];
         do @(posedge clock); while (!csr_ready);
         @(negedge clock);
      end
      csr_valid     <= 1'b0;
      cur_start_low  = start_low;
      cur_release    = release_len;
      cur_thr        = one_thr;
      cur_timeout    = timeout_len;
   endtask

   // Short timings keep a frame near a hundred beats.
   task automatic reconfigure_small();
      int thr;
      thr = $urandom_range(0, 3);
      set_config($urandom_range(1, 4), $urandom_range(0, 3), thr, thr + $urandom_range(4, 8));
   endtask

   // Start command, then ticks through the low and release windows. The line
   // is not looked at there, so feed it random levels.
   task automatic start_reading();
      send_beat(1'b1, 1'($urandom_range(1)));
      repeat (cur_start_low + cur_release) send_beat(1'b0, 1'($urandom_range(1)));
   endtask

   // One sensor answer: response low and high, then nbits bits as a short low
   // and a high whose length carries the bit, then the line goes quiet.
   task automatic send_reading(input int nbits, input bit good_sum);
      logic [4:0][7:0] payload;
      logic            bit_val;
      int              j;
      for (j = 0; j < 4; j++) begin
         case ($urandom_range(7))
            0:       payload[j] = 8'h00;
            1:       payload[j] = 8'hFF;
            default: payload[j] = 8'($urandom);
         endcase
      end
      payload[CHECKSUM_BYTE] = payload[0] + payload[1] + payload[2] + payload[3];
      if (!good_sum) payload[CHECKSUM_BYTE] ^= 8'($urandom_range(1, 255));
      start_reading();
      hold_level(1'b1, $urandom_range(0, 2));
      hold_level(1'b0, $urandom_range(1, 3));
      hold_level(1'b1, $urandom_range(1, 3));
      for (j = 0; j < nbits; j++) begin
         bit_val = (j < FRAME_BITS) ? payload[j / 8][7 - j % 8] : 1'($urandom_range(1));
         hold_level(1'b0, $urandom_range(1, 2));
         if (bit_val)
            hold_level(1'b1, $urandom_range(cur_thr + 1, cur_thr + 2));
         else
            hold_level(1'b1, $urandom_range(1, (cur_thr > 0) ? cur_thr : 1));
      end
      if (nbits > FRAME_BITS) begin
         // the falling edge after the extra bit is the last edge allowed
         send_beat(1'b0, 1'b0);
      end else if ($urandom_range(1)) begin
         hold_level(1'b0, cur_timeout);
      end else begin
         hold_level(1'b0, $urandom_range(1, 2));
         hold_level(1'b1, cur_timeout);
      end
      readings_sent++;
   endtask

   // Well-formed frames with random bytes, some with a bad sum; the rest is over-long
   // and short frames, restarts mid-read and raw line noise.
   task automatic run_random_phase();
      int item_goal;
      int reading_goal;
      int pick;
      item_goal    = items_sent + PHASE_ITEMS;
      reading_goal = readings_sent + PHASE_READINGS;
      while (items_sent < item_goal || readings_sent < reading_goal) begin
         pick = $urandom_range(99);
         if (pick < 40) begin
            send_reading(FRAME_BITS, $urandom_range(3) != 0);
         end else if (pick < 50) begin
            send_reading(FRAME_BITS + 1, 1'b1);
         end else if (pick < 75) begin
            send_reading($urandom_range(FRAME_BITS - 1), 1'($urandom_range(1)));
         end else if (pick < 90) begin
            repeat ($urandom_range(1, 24))
               send_beat($urandom_range(11) == 0, 1'($urandom_range(1)));
         end else begin
            // abandon a read part way; the next start restarts it
            start_reading();
            repeat ($urandom_range(1, 12)) send_beat(1'b0, 1'($urandom_range(1)));
         end
      end
   endtask

   initial begin
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: smallest timings, ticks while idle, restart during the low
      // phase, no release window, and a timeout on the first listening tick.
      set_config(1, 0, 0, 1);
      send_beat(1'b0, 1'b0);
      send_beat(1'b0, 1'b1);
      send_beat(1'b1, 1'b1);
      send_beat(1'b1, 1'b0);
      send_beat(1'b0, 1'b0);
      send_beat(1'b0, 1'b1);
      send_beat(1'b0, 1'b0);
      send_beat(1'b1, 1'b0);
      send_beat(1'b0, 1'b1);
      send_beat(1'b0, 1'b0);

      // Directed: a partial frame of two one bits, then a stuck low times out.
      set_config(2, 1, 0, 3);
      start_reading();
      hold_level(1'b0, 1);
      hold_level(1'b1, 1);
      hold_level(1'b0, 1);
      hold_level(1'b1, 1);
      hold_level(1'b0, 1);
      hold_level(1'b1, 2);
      hold_level(1'b0, 3);

      // Sender idles often, receiver stalls more often.
      req_gap_pct   = 32;
      rsp_stall_pct = 64;
      reconfigure_small();
      run_random_phase();

      // Swap the two.
      req_gap_pct   = 64;
      rsp_stall_pct = 32;
      reconfigure_small();
      run_random_phase();

      // No idling from here on. First a threshold of 254 and the largest timeout: a
      // low level that runs the full 255 samples before the read ends.
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      set_config(1, 2, 254, 255);
      start_reading();
      hold_level(1'b1, 3);
      hold_level(1'b0, 255);

      // Hold the receiver off while a short frame streams in, so the record
      // queue fills and the request side stalls; then pause until all drained.
      reconfigure_small();
      hold_requests <= hold_requests + 1;
      send_reading(8, 1'b1);
      wait_drained();
      run_random_phase();

      wait_drained();
      if (fail_count == 0 && pending == 0)
         $display("single_wire_humidity_sensor_reader_top verification clean");
      else
         $display("single_wire_humidity_sensor_reader_top verification failed");
      $finish;
   end

endmodule : single_wire_humidity_sensor_reader_top_test
